FILE: hdl/handle_free_list_allocator_core_macros.svh
// Assertion macros shared by the handle free-list allocator modules.
`ifndef HANDLE_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define HANDLE_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HFLA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hfla assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define HFLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hfla assertion failed");

`endif

FILE: hdl/hfla_pkg.sv
// Package with types and constants of the handle free-list allocator.
`timescale 1ns / 1ps

package hfla_pkg;

    localparam int MAX_HANDLES = 1024;
    localparam int HANDLE_W    = $clog2(MAX_HANDLES);
    localparam int LINK_W      = HANDLE_W + 1;
    localparam int ENTRY_W     = LINK_W + 1;
    localparam int SIZE_W      = 11;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // End-of-list marker, never a valid handle.
    localparam logic [LINK_W-1:0] INVALID_HANDLE = LINK_W'(MAX_HANDLES);
    localparam logic [SIZE_W-1:0] SIZE_LIMIT     = SIZE_W'(MAX_HANDLES);

    // Register index of pool_size in the register list.
    localparam logic [0:0] REG_POOL_SIZE = 1'b0;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_EMPTY        = 2'd1,
        STATUS_ALREADY_FREE = 2'd2,
        STATUS_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;  // latch request and issue the table read
        logic commit;   // resolve request, update state, load result
    } cmd_t;

    typedef struct packed {
        logic out_free; // result register can take a new word
    } sts_t;

endpackage

FILE: hdl/hfla_ctrl.sv
// Controller state machine of the handle free-list allocator.
`timescale 1ns / 1ps
`include "handle_free_list_allocator_core_macros.svh"

module hfla_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  hfla_pkg::sts_t sts,
    output hfla_pkg::cmd_t cmd
);

    hfla_pkg::state_t state_reg;
    hfla_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hfla_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hfla_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = hfla_pkg::ST_LOOKUP;
                end
            end
            hfla_pkg::ST_LOOKUP: begin
                if (sts.out_free) begin
                    state_next = hfla_pkg::ST_IDLE;
                end
            end
            default: state_next = hfla_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            hfla_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            hfla_pkg::ST_LOOKUP: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    `HFLA_ASSERT_NEXT(a_capture_to_lookup, cmd.capture, state_reg == hfla_pkg::ST_LOOKUP)
    `HFLA_ASSERT_NOW(a_commit_in_lookup, cmd.commit, state_reg == hfla_pkg::ST_LOOKUP && !s_tready)
    `HFLA_ASSERT_NEXT(a_commit_to_idle, cmd.commit, state_reg == hfla_pkg::ST_IDLE)

endmodule

FILE: hdl/hfla_dpath.sv
// Datapath of the handle free-list allocator: link table, head, watermark, result.
`timescale 1ns / 1ps
`include "handle_free_list_allocator_core_macros.svh"

module hfla_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hfla_pkg::cmd_t                 cmd,
    output hfla_pkg::sts_t                 sts,
    input  logic [hfla_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hfla_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hfla_pkg::ADDR_W-1:0]    paddr,
    input  logic [hfla_pkg::DATA_W-1:0]    pwdata,
    output logic [hfla_pkg::DATA_W-1:0]    prdata
);

    localparam int HW = hfla_pkg::HANDLE_W;
    localparam int LW = hfla_pkg::LINK_W;
    localparam int EW = hfla_pkg::ENTRY_W;
    localparam int SW = hfla_pkg::SIZE_W;

    // Table entry: {used, next link}.
    logic [EW-1:0] link_mem [hfla_pkg::MAX_HANDLES];

    logic [SW-1:0] pool_size_reg;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] fresh_reg, fresh_next;     // handles below this have been touched
    logic          kind_reg;
    logic [HW-1:0] handle_reg;
    logic [EW-1:0] rd_data_reg;
    logic          out_valid_reg;
    logic [HW-1:0] out_handle_reg, out_handle_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic [LW-1:0] eff_size;
    logic [SW-1:0] wr_size;
    logic [LW-1:0] wr_eff;
    logic          cfg_wr;
    logic          mem_we;
    logic [HW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [LW-1:0] handle_ext;
    logic [LW-1:0] fresh_link;
    logic          is_fresh;
    logic          entry_used;

    assign eff_size = (pool_size_reg > hfla_pkg::SIZE_LIMIT) ? hfla_pkg::SIZE_LIMIT
                                                             : pool_size_reg;
    assign wr_size  = pwdata[SW-1:0];
    assign wr_eff   = (wr_size > hfla_pkg::SIZE_LIMIT) ? hfla_pkg::SIZE_LIMIT : wr_size;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == hfla_pkg::REG_POOL_SIZE);

    assign sts.out_free = !out_valid_reg || m_tready;

    // Register read-back.
    always_comb begin
        prdata = '0;
        if (paddr[2] == hfla_pkg::REG_POOL_SIZE) begin
            prdata = {{(hfla_pkg::DATA_W - SW){1'b0}}, pool_size_reg};
        end
    end

    // Table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture) begin
            rd_data_reg <= link_mem[(s_tuser[0] == hfla_pkg::KIND_FREE) ?
                                    s_tdata[HW-1:0] : head_reg[HW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_tuser[0];
            handle_reg <= s_tdata[HW-1:0];
        end
    end

    assign handle_ext = {1'b0, handle_reg};
    assign is_fresh   = !(head_reg < fresh_reg);
    assign fresh_link = ((head_reg + LW'(1)) < eff_size) ? (head_reg + LW'(1))
                                                         : hfla_pkg::INVALID_HANDLE;
    assign entry_used = (handle_ext < fresh_reg) && rd_data_reg[EW-1];

    always_comb begin
        head_next       = head_reg;
        fresh_next      = fresh_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_reg[HW-1:0];
        mem_wdata       = {1'b1, hfla_pkg::INVALID_HANDLE};
        out_handle_next = '0;
        out_status_next = hfla_pkg::STATUS_OK;
        if (kind_reg == hfla_pkg::KIND_ALLOC) begin
            if (head_reg[HW]) begin
                out_status_next = hfla_pkg::STATUS_EMPTY;
            end else begin
                out_handle_next = head_reg[HW-1:0];
                mem_we          = cmd.commit;
                if (is_fresh) begin
                    head_next  = fresh_link;
                    fresh_next = fresh_reg + LW'(1);
                end else begin
                    head_next = rd_data_reg[LW-1:0];
                end
            end
        end else begin
            if (!(handle_ext < eff_size)) begin
                out_status_next = hfla_pkg::STATUS_OUT_OF_RANGE;
            end else if (!entry_used) begin
                out_status_next = hfla_pkg::STATUS_ALREADY_FREE;
            end else begin
                mem_we    = cmd.commit;
                mem_waddr = handle_reg;
                mem_wdata = {1'b0, head_reg};
                head_next = handle_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= '0;
            head_reg      <= hfla_pkg::INVALID_HANDLE;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                pool_size_reg <= wr_size;
                head_reg      <= (wr_eff != '0) ? '0 : hfla_pkg::INVALID_HANDLE;
                fresh_reg     <= '0;
            end else if (cmd.commit) begin
                head_reg  <= head_next;
                fresh_reg <= fresh_next;
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_handle_reg <= out_handle_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hfla_pkg::M_TDATA_W - HW - 2){1'b0}}, out_status_reg, out_handle_reg};

    `HFLA_ASSERT_NOW(a_fresh_in_pool, 1'b1, fresh_reg <= eff_size)
    `HFLA_ASSERT_NOW(a_head_in_pool, !head_reg[HW], head_reg < eff_size)
    `HFLA_ASSERT_NOW(a_err_handle_zero, out_valid_reg && out_status_reg != hfla_pkg::STATUS_OK,
                     out_handle_reg == '0)

endmodule

FILE: hdl/handle_free_list_allocator_core.sv
// Top level of the handle free-list allocator: stream request/result and APB config.
// Results: a request word is captured with its link-table read; its result word is
//   loaded (m_tvalid high) when the lookup state commits with the result register free.
// Flow: no new request is accepted until the last one is resolved, due to the registered
//   read of the link table (issue the read, then resolve and write back); a stalled
//   result holds the controller in its lookup state until the result register frees.
// Reset: synchronous, active low; pool size 0, empty free list, no result pending.
//   No clearing pass: a watermark marks table entries never touched since a rebuild.
`timescale 1ns / 1ps

module handle_free_list_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hfla_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] handle, [15:10] zero
    input  logic [0:0]                     s_tuser,   // [0] kind (0 allocate, 1 free)
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hfla_pkg::M_TDATA_W-1:0] m_tdata,   // [9:0] handle_out, [11:10] status,
                                                      // [15:12] zero
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hfla_pkg::ADDR_W-1:0]    paddr,
    input  logic [hfla_pkg::DATA_W-1:0]    pwdata,
    output logic [hfla_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    hfla_pkg::cmd_t cmd;
    hfla_pkg::sts_t sts;

    // Config access always completes in its access cycle.
    assign pready = 1'b1;

    // Sequence each word: accept, read the link table, then resolve and write back.
    hfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the free list, used bits, pool size and the result register.
    hfla_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule
